/* design/stks_pkg.sv */
// ----------------------------------------------------------------------------
// stks_pkg: shared types and constants for the streaming top-k selector
// Sizes of the cell chain, control codes for the cells and the keep-count
// clamp used by the top level.
// ----------------------------------------------------------------------------
package stks_pkg;

  localparam int MAX_KEEP = 64;
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 7;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] KEEP_RESET = 7'd64;

  typedef enum logic {
    S_COLLECT,
    S_DRAIN
  } state_t;

  // One operation per cycle is broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // sorted insert of the key
    logic rep;    // drop the smallest entry and insert the key
    logic shift;  // move every entry one cell toward the output
  } cell_ctrl_t;

  // A keep count of zero acts as one; counts above the chain length saturate.
  function automatic logic [CMP_W-1:0] eff_keep(input logic [CFG_W-1:0] k);
    logic [CMP_W-1:0] kx;
    kx = CMP_W'(k);
    if (k == '0) begin
      return CMP_W'(1);
    end else if (kx > CMP_W'(MAX_KEEP)) begin
      return CMP_W'(MAX_KEEP);
    end else begin
      return kx;
    end
  endfunction

endpackage

/* design/stks_cell.sv */
// ----------------------------------------------------------------------------
// stks_cell: one entry of the sorted keep chain
// Holds one value and its valid bit, compares it against the incoming key
// and takes its new contents from itself, the key or a neighbor.
// ----------------------------------------------------------------------------
module stks_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  stks_pkg::cell_ctrl_t              ctrl,
  input  logic signed [stks_pkg::DATA_W-1:0] key,
  input  logic signed [stks_pkg::DATA_W-1:0] prev_val,
  input  logic                              prev_vld,
  input  logic                              prev_below,
  input  logic signed [stks_pkg::DATA_W-1:0] next_val,
  input  logic                              next_vld,
  input  logic                              next_lt,
  output logic signed [stks_pkg::DATA_W-1:0] val,
  output logic                              vld,
  output logic                              below,
  output logic                              lt
);

  logic signed [stks_pkg::DATA_W-1:0] val_next;
  logic                              vld_next;

  // below: this entry is not greater than the key; lt: strictly less.
  assign below = vld && !(val > key);
  assign lt    = vld && (val < key);

  always_comb begin
    val_next = val;
    vld_next = vld;
    if (ctrl.shift) begin
      val_next = next_val;
      vld_next = next_vld;
    end else if (ctrl.ins) begin
      // Entries not above the key stay; the first cell above them takes the key
      // and every later cell takes its lower neighbor.
      if (!below) begin
        if (prev_below) begin
          val_next = key;
          vld_next = 1'b1;
        end else begin
          val_next = prev_val;
          vld_next = prev_vld;
        end
      end
    end else if (ctrl.rep) begin
      if (next_lt) begin
        val_next = next_val;
      end else if (lt) begin
        val_next = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

/* design/streaming_top_k_select.sv */
// ----------------------------------------------------------------------------
// streaming_top_k_select: keeps the largest values of a signed stream
// A row of compare cells holds the kept values in ascending order; the
// marked end of a stream drains them smallest first and empties the row.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  --------------------------------
//  input    in_valid / in_ready        sample_value, stream_end
//  output   out_valid / out_ready      kept_value, final_of_run
//  config   cfg_write (no wait)        cfg_data (keep count)
//
// One input value is taken per cycle while collecting; every cell compares
// it with its own entry in the same cycle, so the insert completes at once.
// After the value marked as stream end, the kept values drain one per output
// transfer, during which in_ready is low.
// An output stall simply holds the head cell; reset empties the chain.
module streaming_top_k_select (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [stks_pkg::DATA_W-1:0] sample_value,
  input  logic                               stream_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [stks_pkg::DATA_W-1:0] kept_value,
  output logic                               final_of_run,
  input  logic                               cfg_write,
  input  logic [stks_pkg::CFG_W-1:0]         cfg_data
);

  localparam int N = stks_pkg::MAX_KEEP;

  stks_pkg::state_t     state, state_next;
  stks_pkg::cell_ctrl_t ctrl;

  logic [stks_pkg::CFG_W-1:0] keep_count;
  logic [stks_pkg::CNT_W-1:0] held_count, held_count_next;

  logic signed [stks_pkg::DATA_W-1:0] cell_val [N];
  logic                               cell_vld [N];
  logic                               cell_below [N];
  logic                               cell_lt [N];

  logic in_xfer, out_xfer, insert_mode, last_out;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  assign insert_mode = stks_pkg::CMP_W'(held_count) < stks_pkg::eff_keep(keep_count);

  generate
    for (genvar i = 0; i < N; i++) begin : g_cell
      logic signed [stks_pkg::DATA_W-1:0] pv, nv;
      logic                               pvld, pb, nvld, nlt;
      if (i == 0) begin : g_head
        assign pv   = sample_value;
        assign pvld = 1'b0;
        assign pb   = 1'b1;
      end else begin : g_mid
        assign pv   = cell_val[i-1];
        assign pvld = cell_vld[i-1];
        assign pb   = cell_below[i-1];
      end
      if (i == N - 1) begin : g_tail
        assign nv   = '0;
        assign nvld = 1'b0;
        assign nlt  = 1'b0;
      end else begin : g_inner
        assign nv   = cell_val[i+1];
        assign nvld = cell_vld[i+1];
        assign nlt  = cell_lt[i+1];
      end
      stks_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (sample_value),
        .prev_val   (pv),
        .prev_vld   (pvld),
        .prev_below (pb),
        .next_val   (nv),
        .next_vld   (nvld),
        .next_lt    (nlt),
        .val        (cell_val[i]),
        .vld        (cell_vld[i]),
        .below      (cell_below[i]),
        .lt         (cell_lt[i])
      );
    end
    if (N == 1) begin : g_last_one
      assign last_out = 1'b1;
    end else begin : g_last_many
      assign last_out = !cell_vld[1];
    end
  endgenerate

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      stks_pkg::S_COLLECT: if (in_xfer && stream_end) state_next = stks_pkg::S_DRAIN;
      stks_pkg::S_DRAIN:   if (out_xfer && last_out) state_next = stks_pkg::S_COLLECT;
      default:             state_next = stks_pkg::S_COLLECT;
    endcase
  end

  // Outputs and cell control.
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctrl       = '0;
    unique case (state)
      stks_pkg::S_COLLECT: begin
        in_ready = 1'b1;
        ctrl.ins = in_xfer && insert_mode;
        ctrl.rep = in_xfer && !insert_mode && cell_lt[0];
      end
      stks_pkg::S_DRAIN: begin
        out_valid  = 1'b1;
        ctrl.shift = out_xfer;
      end
      default: ;
    endcase
  end

  assign kept_value   = cell_val[0];
  assign final_of_run = last_out;

  always_comb begin
    held_count_next = held_count;
    if (ctrl.ins) begin
      held_count_next = held_count + stks_pkg::CNT_W'(1);
    end else if (out_xfer && last_out) begin
      held_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stks_pkg::S_COLLECT;
      held_count <= '0;
      keep_count <= stks_pkg::KEEP_RESET;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      if (cfg_write) begin
        keep_count <= cfg_data;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open at the same time");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_vld[0])
    else $error("drain presents an empty head cell");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    (held_count != '0) == cell_vld[0])
    else $error("held count disagrees with the cell chain");

  a_end_drains: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && stream_end) |=> out_valid)
    else $error("stream end did not start a drain");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for streaming_top_k_select
// Feeds signed value streams under several keep counts. A model of the
// sorted store tracks each stream and queues the drained values in output
// order. Every output transfer is checked against that queue, while
// both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_OFF     = 400;
  localparam int RANDOM_ITEMS = 340;
  localparam int SETTLE       = 4;

  typedef struct packed {
    logic signed [stks_pkg::DATA_W-1:0] value;
    logic                               is_final;
  } drained_t;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [stks_pkg::DATA_W-1:0] sample_value;
  logic                               stream_end;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [stks_pkg::DATA_W-1:0] kept_value;
  logic                               final_of_run;
  logic                               cfg_write;
  logic [stks_pkg::CFG_W-1:0]         cfg_data;

  // Model of the store: values held in ascending order.
  logic signed [stks_pkg::DATA_W-1:0] top_vals [stks_pkg::MAX_KEEP];
  int                                 top_count;
  logic [stks_pkg::CFG_W-1:0]         keep_reg;
  drained_t                           drain_order [$];

  int  fail_count;
  int  cycle_count;
  int  burst_left;
  int  gap_max;
  bit  offer_open;
  bit  ready_steady;
  bit  hold_off_req;
  int  samples_sent;

  streaming_top_k_select dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kept_value   (kept_value),
    .final_of_run (final_of_run),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int keep_limit(logic [stks_pkg::CFG_W-1:0] k);
    if (k == '0) begin
      return 1;
    end else if (int'(k) > stks_pkg::MAX_KEEP) begin
      return stks_pkg::MAX_KEEP;
    end else begin
      return int'(k);
    end
  endfunction

  function automatic void track_top_values(logic signed [stks_pkg::DATA_W-1:0] v,
                                           logic last);
    int       pos;
    drained_t d;
    if (top_count < keep_limit(keep_reg)) begin
      pos = top_count;
      while (pos > 0 && top_vals[pos-1] > v) begin
        top_vals[pos] = top_vals[pos-1];
        pos--;
      end
      top_vals[pos] = v;
      top_count++;
    end else if (top_count > 0 && v > top_vals[0]) begin
      // The smallest value drops out; slide the new one into place.
      pos = 0;
      while (pos + 1 < top_count && top_vals[pos+1] < v) begin
        top_vals[pos] = top_vals[pos+1];
        pos++;
      end
      top_vals[pos] = v;
    end
    if (last) begin
      for (int i = 0; i < top_count; i++) begin
        d.value    = top_vals[i];
        d.is_final = (i == top_count - 1);
        drain_order.push_back(d);
      end
      top_count = 0;
    end
  endfunction

  // Offers one value and returns once it has been transferred. The valid
  // stays up across back-to-back transfers and drops only for a gap.
  task automatic send_sample(input logic signed [stks_pkg::DATA_W-1:0] v,
                             input logic last);
    int gap;
    sample_value <= v;
    stream_end   <= last;
    in_valid     <= 1'b1;
    offer_open = 1'b1;
    do @(posedge clk); while (!in_ready);
    track_top_values(v, last);
    samples_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        offer_open = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle;
    if (offer_open) begin
      in_valid <= 1'b0;
      offer_open = 1'b0;
    end
    while (drain_order.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_keep(input logic [stks_pkg::CFG_W-1:0] k);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    cfg_write <= 1'b0;
    keep_reg = k;
  endtask

  function automatic logic signed [stks_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  // Reset keep count of 64, field extremes and a stream of a single value.
  task automatic test_default_keep;
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b1);
    send_sample(32'sh5555_AAAA, 1'b1);
  endtask

  // A zero keep count behaves as one; one keeps only the largest value.
  task automatic test_single_keep;
    set_keep(7'd0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd3, 1'b0);
    send_sample(32'sd9, 1'b1);
    set_keep(7'd1);
    send_sample(-32'sd5, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
  endtask

  // Equal values never displace a held one.
  task automatic test_ties;
    set_keep(7'd2);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd6, 1'b0);
    send_sample(32'sd5, 1'b1);
  endtask

  // Lowering the keep count in the middle of a stream keeps what is held.
  task automatic test_keep_lowered;
    set_keep(7'd4);
    send_sample(32'sd10, 1'b0);
    send_sample(32'sd20, 1'b0);
    send_sample(32'sd30, 1'b0);
    send_sample(32'sd40, 1'b0);
    set_keep(7'd2);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd25, 1'b1);
  endtask

  // A keep count above the store size saturates; the stream overflows it.
  task automatic test_keep_saturation;
    set_keep(7'd127);
    for (int i = 0; i < 70; i++) send_sample(pick_value(), i == 69);
  endtask

  // The receiver holds off for a long stretch while values keep coming, so
  // drains stall and the input backs up.
  task automatic test_backpressure;
    set_keep(7'd8);
    gap_max      = 0;
    ready_steady = 1'b1;
    hold_off_req = 1'b1;
    for (int s = 0; s < 3; s++) begin
      for (int i = 0; i < 12; i++) send_sample(pick_value(), i == 11);
    end
  endtask

  task automatic test_random_streams;
    int                         streams;
    int                         len;
    int                         lim;
    bit                         close_last;
    logic [stks_pkg::CFG_W-1:0] k;
    samples_sent = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 15))
        0: k = 7'd0;
        1: k = 7'd127;
        2: k = 7'd64;
        3: k = 7'($urandom_range(65, 126));
        4: k = 7'($urandom_range(0, 127));
        default: k = 7'($urandom_range(1, 8));
      endcase
      set_keep(k);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 8;
      endcase
      ready_steady = ($urandom_range(0, 3) == 0);
      lim = keep_limit(k);
      streams = $urandom_range(1, 4);
      // Now and then the phase ends mid-stream, so the next keep count
      // lands on a partly filled store.
      close_last = ($urandom_range(0, 3) != 0);
      for (int s = 0; s < streams; s++) begin
        len = (lim > 16) ? $urandom_range(1, lim + 8) : $urandom_range(1, 2 * lim + 4);
        for (int i = 0; i < len; i++) begin
          send_sample(pick_value(), (i == len - 1) && (close_last || s < streams - 1));
        end
      end
    end
    send_sample(pick_value(), 1'b1);
  endtask

  // Receiver: alternating runs of ready and stall, or steady, with one
  // long hold-off on request.
  initial begin
    int  hold_left;
    int  run_left;
    bit  run_high;
    hold_left = 0;
    run_left  = 0;
    run_high  = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_steady) begin
        out_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_high = !run_high;
          run_left = run_high ? $urandom_range(1, 8) : $urandom_range(1, 5);
        end
        run_left--;
        out_ready <= run_high;
      end
    end
  end

  always @(posedge clk) begin
    drained_t d;
    if (!rst && out_valid && out_ready) begin
      if (drain_order.size() == 0) begin
        $error("kept_value transfer with nothing pending: got %0d", kept_value);
        fail_count++;
      end else begin
        d = drain_order.pop_front();
        if (kept_value !== d.value) begin
          $error("kept_value mismatch: expected %0d, actual %0d", d.value, kept_value);
          fail_count++;
        end
        if (final_of_run !== d.is_final) begin
          $error("final_of_run mismatch: expected %0b, actual %0b", d.is_final,
                 final_of_run);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample_value = '0;
    stream_end   = 1'b0;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    keep_reg     = stks_pkg::KEEP_RESET;
    top_count    = 0;
    fail_count   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    gap_max      = 3;
    offer_open   = 1'b0;
    ready_steady = 1'b0;
    hold_off_req = 1'b0;
    samples_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_keep();
    test_single_keep();
    test_ties();
    test_keep_lowered();
    test_keep_saturation();
    test_backpressure();
    test_random_streams();

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* streaming_top_k_select.f */
design/stks_pkg.sv
design/stks_cell.sv
design/streaming_top_k_select.sv
tb/sv/tb.sv
